// ----- rtl/core/adsr_pkg.sv -----
// Shared types, constants and helper functions for the ADSR envelope generator.
`timescale 1ns / 1ps

package adsr_pkg;

    // Core widths
    localparam int LEVEL_FRAC_BITS = 23;
    localparam int SAMPLE_BITS     = 24;
    localparam int STEP_COUNT_BITS = 20;

    localparam int LEVEL_W   = LEVEL_FRAC_BITS + 1;   // Q1.F level, unsigned
    localparam int FACTOR_W  = LEVEL_FRAC_BITS;       // Q0.F factor, unsigned
    localparam int DELTA_W   = LEVEL_FRAC_BITS + 2;   // signed Q1.F delta
    localparam int SUM_W     = LEVEL_FRAC_BITS + 3;   // level plus delta
    localparam int MUL_W     = (DELTA_W > SAMPLE_BITS) ? DELTA_W : SAMPLE_BITS;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int RND_W     = PROD_W - LEVEL_FRAC_BITS;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = (STEP_COUNT_BITS > LEVEL_W) ? STEP_COUNT_BITS : LEVEL_W;

    // Fixed-point constants
    localparam longint ONE_VAL        = 64'sd1 <<< LEVEL_FRAC_BITS;
    localparam longint HALF_VAL       = 64'sd1 <<< (LEVEL_FRAC_BITS - 1);
    localparam longint RATIO_DEC_VAL  = (ONE_VAL + 5000) / 10000;
    localparam longint RATIO_REL_VAL  = (ONE_VAL + 5) / 10;
    localparam longint SAMPLE_MAX_VAL = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN_VAL = -(64'sd1 <<< (SAMPLE_BITS - 1));

    localparam logic [LEVEL_W-1:0]      LEVEL_ONE     = LEVEL_W'(ONE_VAL);
    localparam logic signed [MUL_W-1:0] RATIO_DECAY   = MUL_W'(RATIO_DEC_VAL);
    localparam logic signed [MUL_W-1:0] RATIO_RELEASE = MUL_W'(RATIO_REL_VAL);
    localparam logic signed [PROD_W-1:0] ROUND_HALF   = PROD_W'(HALF_VAL);

    // Register reset values
    localparam logic [STEP_COUNT_BITS-1:0] RST_ATTACK_STEPS  = STEP_COUNT_BITS'(96);
    localparam logic [LEVEL_W-1:0]         RST_ATTACK_INC    = LEVEL_W'(87381);
    localparam logic [STEP_COUNT_BITS-1:0] RST_DECAY_STEPS   = STEP_COUNT_BITS'(1276);
    localparam logic [FACTOR_W-1:0]        RST_DECAY_FACTOR  = FACTOR_W'(8328270);
    localparam logic [STEP_COUNT_BITS-1:0] RST_RELEASE_STEPS = STEP_COUNT_BITS'(380);
    localparam logic [FACTOR_W-1:0]        RST_REL_FACTOR    = FACTOR_W'(8335608);
    localparam logic [LEVEL_W-1:0]         RST_SUSTAIN       = LEVEL_W'(8388608);

    // Request opcodes
    typedef enum logic [1:0] {
        OP_SAMPLE   = 2'd0,
        OP_NOTE_ON  = 2'd1,
        OP_NOTE_OFF = 2'd2,
        OP_RESERVED = 2'd3
    } opcode_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ATTACK_STEPS   = 3'd0,
        REG_ATTACK_INC     = 3'd1,
        REG_DECAY_STEPS    = 3'd2,
        REG_DECAY_FACTOR   = 3'd3,
        REG_RELEASE_STEPS  = 3'd4,
        REG_RELEASE_FACTOR = 3'd5,
        REG_SUSTAIN_LEVEL  = 3'd6
    } cfg_reg_t;

    // Envelope phase, one-hot
    typedef enum logic [4:0] {
        PH_ATTACK  = 5'b00001,
        PH_DECAY   = 5'b00010,
        PH_SUSTAIN = 5'b00100,
        PH_RELEASE = 5'b01000,
        PH_DONE    = 5'b10000
    } phase_t;

    // Operand pair for the shared multiplier
    typedef enum logic [2:0] {
        MUL_DECAY_RATIO   = 3'd0,
        MUL_RELEASE_RATIO = 3'd1,
        MUL_DELTA         = 3'd2,
        MUL_STEP          = 3'd3,
        MUL_OUT           = 3'd4
    } mul_sel_t;

    // Channel payloads
    typedef struct packed {
        opcode_t                       opcode;
        logic signed [SAMPLE_BITS-1:0] sample_in;
    } adsr_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic [LEVEL_W-1:0]            envelope_level;
        logic                          finished;
    } adsr_out_t;

    // Controller to datapath
    typedef struct packed {
        logic     in_accept;
        logic     attack_load;
        logic     lin_step;
        logic     exp_step;
        logic     used_hold;
        logic     snap;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     rnd_en;
        logic     a_load;
        logic     seg_load;
        logic     seg_decay;
        logic     out_load;
        logic     out_finished;
    } adsr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic rem_zero;
        logic linear;
    } adsr_status_t;

    // Clamp a level sum to [0, ONE]
    function automatic logic [LEVEL_W-1:0] clamp_level(input logic signed [SUM_W-1:0] v);
        logic [LEVEL_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > ONE_VAL) begin
            r = LEVEL_ONE;
        end else begin
            r = LEVEL_W'(v);
        end
        return r;
    endfunction

    // Saturate a rounded product to the signed sample range
    function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(
        input logic signed [RND_W-1:0] v
    );
        logic signed [SAMPLE_BITS-1:0] r;
        if (v > SAMPLE_MAX_VAL) begin
            r = SAMPLE_BITS'(SAMPLE_MAX_VAL);
        end else if (v < SAMPLE_MIN_VAL) begin
            r = SAMPLE_BITS'(SAMPLE_MIN_VAL);
        end else begin
            r = SAMPLE_BITS'(v);
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/adsr_datapath.sv -----
// Datapath: config registers, envelope state, shared multiplier, rounding and output register.
`timescale 1ns / 1ps

module adsr_datapath
    import adsr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  adsr_in_t              s_payload,
    input  adsr_cmd_t             cmd,
    output adsr_status_t          status,
    output adsr_out_t             m_payload
);

    // Configuration registers
    logic [STEP_COUNT_BITS-1:0] attack_steps_reg;
    logic [LEVEL_W-1:0]         attack_inc_reg;
    logic [STEP_COUNT_BITS-1:0] decay_steps_reg;
    logic [FACTOR_W-1:0]        decay_factor_reg;
    logic [STEP_COUNT_BITS-1:0] release_steps_reg;
    logic [FACTOR_W-1:0]        release_factor_reg;
    logic [LEVEL_W-1:0]         sustain_reg;

    // Envelope state
    logic [LEVEL_W-1:0]         level_reg;
    logic [STEP_COUNT_BITS-1:0] remaining_reg;
    logic [LEVEL_W-1:0]         factor_reg;
    logic signed [DELTA_W-1:0]  delta_reg;
    logic [LEVEL_W-1:0]         target_reg;
    logic                       linear_reg;

    // Working registers
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [LEVEL_W-1:0]            used_reg;
    logic signed [DELTA_W-1:0]     a_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [RND_W-1:0]       rnd_reg;
    adsr_out_t                     out_reg;

    logic [LEVEL_W-1:0]        sustain_clamped;
    logic [FACTOR_W-1:0]       seg_factor;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  rnd_sum;
    logic signed [SUM_W-1:0]   lin_sum;
    logic signed [SUM_W-1:0]   exp_sum;
    logic [LEVEL_W-1:0]        lin_level;
    logic [LEVEL_W-1:0]        exp_level;
    logic signed [DELTA_W-1:0] a_next;

    assign sustain_clamped = (sustain_reg > LEVEL_ONE) ? LEVEL_ONE : sustain_reg;
    assign seg_factor      = cmd.seg_decay ? decay_factor_reg : release_factor_reg;

    // Operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_sel)
            MUL_DECAY_RATIO: begin
                mul_a = RATIO_DECAY;
                mul_b = MUL_W'($signed({1'b0, LEVEL_ONE - sustain_clamped}));
            end
            MUL_RELEASE_RATIO: begin
                mul_a = RATIO_RELEASE;
                mul_b = MUL_W'($signed({1'b0, level_reg}));
            end
            MUL_DELTA: begin
                mul_a = MUL_W'(a_reg);
                mul_b = MUL_W'($signed({1'b0, LEVEL_ONE - LEVEL_W'(seg_factor)}));
            end
            MUL_STEP: begin
                mul_a = MUL_W'($signed({1'b0, level_reg}));
                mul_b = MUL_W'($signed({1'b0, factor_reg}));
            end
            MUL_OUT: begin
                mul_a = MUL_W'(sample_reg);
                mul_b = MUL_W'($signed({1'b0, used_reg}));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Round to nearest, ties away from zero
    assign rnd_sum = prod_reg + ROUND_HALF - PROD_W'(prod_reg[PROD_W-1]);

    // Level updates
    assign lin_sum   = SUM_W'($signed({1'b0, level_reg})) + SUM_W'(delta_reg);
    assign exp_sum   = SUM_W'(rnd_reg) + SUM_W'(delta_reg);
    assign lin_level = clamp_level(lin_sum);
    assign exp_level = clamp_level(exp_sum);

    // Segment set-up offset: sustain minus overshoot, or minus the release ratio times the level
    assign a_next = cmd.seg_decay
        ? ($signed({1'b0, sustain_clamped}) - DELTA_W'(rnd_reg))
        : (-DELTA_W'(rnd_reg));

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_steps_reg   <= RST_ATTACK_STEPS;
            attack_inc_reg     <= RST_ATTACK_INC;
            decay_steps_reg    <= RST_DECAY_STEPS;
            decay_factor_reg   <= RST_DECAY_FACTOR;
            release_steps_reg  <= RST_RELEASE_STEPS;
            release_factor_reg <= RST_REL_FACTOR;
            sustain_reg        <= RST_SUSTAIN;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ATTACK_STEPS:   attack_steps_reg   <= STEP_COUNT_BITS'(cfg_data);
                REG_ATTACK_INC:     attack_inc_reg     <= LEVEL_W'(cfg_data);
                REG_DECAY_STEPS:    decay_steps_reg    <= STEP_COUNT_BITS'(cfg_data);
                REG_DECAY_FACTOR:   decay_factor_reg   <= FACTOR_W'(cfg_data);
                REG_RELEASE_STEPS:  release_steps_reg  <= STEP_COUNT_BITS'(cfg_data);
                REG_RELEASE_FACTOR: release_factor_reg <= FACTOR_W'(cfg_data);
                REG_SUSTAIN_LEVEL:  sustain_reg        <= LEVEL_W'(cfg_data);
                default: ;
            endcase
        end
    end

    // Envelope state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg     <= '0;
            remaining_reg <= '0;
            factor_reg    <= '0;
            delta_reg     <= '0;
            target_reg    <= '0;
            linear_reg    <= 1'b0;
        end else begin
            if (cmd.attack_load) begin
                level_reg     <= '0;
                remaining_reg <= attack_steps_reg;
                factor_reg    <= LEVEL_ONE;
                delta_reg     <= $signed({1'b0, attack_inc_reg});
                target_reg    <= LEVEL_ONE;
                linear_reg    <= 1'b1;
            end
            if (cmd.lin_step) begin
                level_reg     <= lin_level;
                remaining_reg <= remaining_reg - 1'b1;
            end
            if (cmd.exp_step) begin
                level_reg     <= exp_level;
                remaining_reg <= remaining_reg - 1'b1;
            end
            if (cmd.snap) begin
                level_reg <= target_reg;
            end
            if (cmd.seg_load) begin
                delta_reg  <= DELTA_W'(rnd_reg);
                linear_reg <= 1'b0;
                if (cmd.seg_decay) begin
                    factor_reg    <= LEVEL_W'(decay_factor_reg);
                    target_reg    <= sustain_clamped;
                    remaining_reg <= decay_steps_reg;
                end else begin
                    factor_reg    <= LEVEL_W'(release_factor_reg);
                    target_reg    <= '0;
                    remaining_reg <= release_steps_reg;
                end
            end
        end
    end

    // Working registers and output register
    always_ff @(posedge aclk) begin
        if (cmd.in_accept) begin
            sample_reg <= s_payload.sample_in;
        end
        if (cmd.lin_step) begin
            used_reg <= lin_level;
        end else if (cmd.exp_step) begin
            used_reg <= exp_level;
        end else if (cmd.used_hold) begin
            used_reg <= level_reg;
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.rnd_en) begin
            rnd_reg <= RND_W'(rnd_sum >>> LEVEL_FRAC_BITS);
        end
        if (cmd.a_load) begin
            a_reg <= a_next;
        end
        if (cmd.out_load) begin
            out_reg.sample_out     <= clamp_sample(rnd_reg);
            out_reg.envelope_level <= used_reg;
            out_reg.finished       <= cmd.out_finished;
        end
    end

    assign status.rem_zero = (remaining_reg == '0);
    assign status.linear   = linear_reg;
    assign m_payload       = out_reg;

endmodule

// ----- rtl/core/adsr_ctrl.sv -----
// Controller: request sequencing, envelope phase and output valid.
`timescale 1ns / 1ps

module adsr_ctrl
    import adsr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  opcode_t      s_opcode,
    output logic         m_valid,
    input  logic         m_ready,
    input  adsr_status_t status,
    output adsr_cmd_t    cmd
);

    typedef enum logic [14:0] {
        ST_IDLE     = 15'b000000000000001,
        ST_STEP     = 15'b000000000000010,
        ST_EXP_MUL  = 15'b000000000000100,
        ST_EXP_RND  = 15'b000000000001000,
        ST_EXP_ADD  = 15'b000000000010000,
        ST_POST     = 15'b000000000100000,
        ST_RAT_MUL  = 15'b000000001000000,
        ST_RAT_RND  = 15'b000000010000000,
        ST_RAT_A    = 15'b000000100000000,
        ST_DLT_MUL  = 15'b000001000000000,
        ST_DLT_RND  = 15'b000010000000000,
        ST_SEG_LOAD = 15'b000100000000000,
        ST_OUT_MUL  = 15'b001000000000000,
        ST_OUT_RND  = 15'b010000000000000,
        ST_OUT_WR   = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   seg_decay_reg, seg_decay_next;
    logic   resume_reg, resume_next;
    logic   m_valid_reg, m_valid_next;
    logic   phase_active;
    logic   out_free;

    assign phase_active = (phase_reg == PH_ATTACK) || (phase_reg == PH_DECAY) ||
                          (phase_reg == PH_RELEASE);
    assign out_free     = !m_valid_reg || m_ready;
    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        seg_decay_next = seg_decay_reg;
        resume_next    = resume_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        cmd            = '0;
        cmd.seg_decay  = seg_decay_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.in_accept = 1'b1;
                    case (s_opcode)
                        OP_NOTE_ON: begin
                            cmd.attack_load = 1'b1;
                            phase_next      = PH_ATTACK;
                        end
                        OP_NOTE_OFF: begin
                            seg_decay_next = 1'b0;
                            state_next     = ST_RAT_MUL;
                        end
                        OP_SAMPLE: begin
                            state_next = ST_STEP;
                        end
                        default: ;
                    endcase
                end
            end
            ST_STEP: begin
                if (!phase_active) begin
                    cmd.used_hold = 1'b1;
                    state_next    = ST_OUT_MUL;
                end else if (status.rem_zero) begin
                    // empty segment: snap and let the next phase take this sample
                    cmd.snap = 1'b1;
                    if (phase_reg == PH_ATTACK) begin
                        seg_decay_next = 1'b1;
                        resume_next    = 1'b1;
                        state_next     = ST_RAT_MUL;
                    end else if (phase_reg == PH_DECAY) begin
                        phase_next = PH_SUSTAIN;
                    end else begin
                        phase_next = PH_DONE;
                    end
                end else if (status.linear) begin
                    cmd.lin_step = 1'b1;
                    state_next   = ST_POST;
                end else begin
                    state_next = ST_EXP_MUL;
                end
            end
            ST_EXP_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_STEP;
                state_next  = ST_EXP_RND;
            end
            ST_EXP_RND: begin
                cmd.rnd_en = 1'b1;
                state_next = ST_EXP_ADD;
            end
            ST_EXP_ADD: begin
                cmd.exp_step = 1'b1;
                state_next   = ST_POST;
            end
            ST_POST: begin
                // last step of a segment: output keeps the stepped level
                state_next = ST_OUT_MUL;
                if (status.rem_zero) begin
                    cmd.snap = 1'b1;
                    if (phase_reg == PH_ATTACK) begin
                        seg_decay_next = 1'b1;
                        resume_next    = 1'b0;
                        state_next     = ST_RAT_MUL;
                    end else if (phase_reg == PH_DECAY) begin
                        phase_next = PH_SUSTAIN;
                    end else begin
                        phase_next = PH_DONE;
                    end
                end
            end
            ST_RAT_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = seg_decay_reg ? MUL_DECAY_RATIO : MUL_RELEASE_RATIO;
                state_next  = ST_RAT_RND;
            end
            ST_RAT_RND: begin
                cmd.rnd_en = 1'b1;
                state_next = ST_RAT_A;
            end
            ST_RAT_A: begin
                cmd.a_load = 1'b1;
                state_next = ST_DLT_MUL;
            end
            ST_DLT_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DELTA;
                state_next  = ST_DLT_RND;
            end
            ST_DLT_RND: begin
                cmd.rnd_en = 1'b1;
                state_next = ST_SEG_LOAD;
            end
            ST_SEG_LOAD: begin
                cmd.seg_load = 1'b1;
                if (seg_decay_reg) begin
                    phase_next = PH_DECAY;
                    state_next = resume_reg ? ST_STEP : ST_OUT_MUL;
                end else begin
                    phase_next = PH_RELEASE;
                    state_next = ST_IDLE;
                end
            end
            ST_OUT_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_OUT;
                state_next  = ST_OUT_RND;
            end
            ST_OUT_RND: begin
                cmd.rnd_en = 1'b1;
                state_next = ST_OUT_WR;
            end
            ST_OUT_WR: begin
                // wait here while the previous result is still unclaimed
                if (out_free) begin
                    cmd.out_load     = 1'b1;
                    cmd.out_finished = (phase_reg == PH_DONE);
                    m_valid_next     = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_DONE;
            seg_decay_reg <= 1'b0;
            resume_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            seg_decay_reg <= seg_decay_next;
            resume_reg    <= resume_next;
            m_valid_reg   <= m_valid_next;
        end
    end

endmodule

// ----- rtl/core/adsr_envelope_generator.sv -----
// Top level of the ADSR envelope generator: controller plus datapath.
//
// Usage:
//   s_ channel (valid/ready) carries requests: opcode 0 scales sample_in by the
//   envelope, opcode 1 retriggers the envelope (note on), opcode 2 starts the
//   release (note off), opcode 3 is dropped. Only sample requests give a result.
//   m_ channel (valid/ready) returns sample_out, envelope_level and finished.
//   cfg_ channel writes one of the seven envelope registers per request; it is
//   always ready and is meant to be written while the block is idle.
// Operation:
//   One request is worked on at a time, all multiplies going through one shared
//   multiplier followed by a rounding register. Note off takes two multiplies
//   for the release slope. A sample steps the envelope linearly or
//   exponentially, and when an attack segment ends the decay slope is set up
//   on the way.
// Reset:
//   aresetn (synchronous, active low) loads the register defaults, sets the
//   envelope to the done phase at level zero and clears the output valid.
// Stall:
//   The result register holds while m_ready is low; a new request is still
//   taken and worked on, and its result waits until the register frees up.
`timescale 1ns / 1ps

module adsr_envelope_generator
    import adsr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  adsr_in_t              s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output adsr_out_t             m_payload
);

    adsr_cmd_t    cmd;
    adsr_status_t status;

    assign cfg_ready = 1'b1;

    adsr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_payload.opcode),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .status   (status),
        .cmd      (cmd)
    );

    adsr_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_payload (s_payload),
        .cmd       (cmd),
        .status    (status),
        .m_payload (m_payload)
    );

endmodule

// ----- tb/tb_adsr_envelope_generator.sv -----
// Self-checking testbench for the ADSR envelope generator: directed and random requests.
`timescale 1ns / 1ps

module tb_adsr_envelope_generator
    import adsr_pkg::*;
;

    localparam int NUM_REGS        = 7;
    localparam int SETTLE_CYCLES   = 32;
    localparam int PHASE_COUNT     = 10;
    localparam int REQS_PER_PHASE  = 155;

    // Envelope tracker: mirrors the generator state and holds the results still owed
    class envelope_tracker;
        logic [STEP_COUNT_BITS-1:0] attack_span, decay_span, release_span;
        logic [LEVEL_W-1:0]         attack_inc, sustain;
        logic [FACTOR_W-1:0]        decay_mul, release_mul;
        phase_t                     phase;
        logic [LEVEL_W-1:0]         level, target;
        logic [STEP_COUNT_BITS-1:0] steps_left;
        logic [LEVEL_W-1:0]         slope_mul;
        logic signed [DELTA_W-1:0]  slope_add;
        bit                         linear;
        adsr_out_t                  pending_outputs[$];
        int unsigned                mismatches;

        function new();
            attack_span  = RST_ATTACK_STEPS;
            attack_inc   = RST_ATTACK_INC;
            decay_span   = RST_DECAY_STEPS;
            decay_mul    = RST_DECAY_FACTOR;
            release_span = RST_RELEASE_STEPS;
            release_mul  = RST_REL_FACTOR;
            sustain      = RST_SUSTAIN;
            phase        = PH_DONE;
            level        = '0;
            target       = '0;
            steps_left   = '0;
            slope_mul    = '0;
            slope_add    = '0;
            linear       = 1'b0;
            mismatches   = 0;
        endfunction

        // Q1.F product shift, round to nearest with ties away from zero
        function longint round_q(longint v);
            if (v >= 0) begin
                return (v + HALF_VAL) >>> LEVEL_FRAC_BITS;
            end
            return -(((-v) + HALF_VAL) >>> LEVEL_FRAC_BITS);
        endfunction

        function logic [LEVEL_W-1:0] sat_level(longint v);
            if (v < 0) begin
                return '0;
            end
            if (v > ONE_VAL) begin
                return LEVEL_W'(ONE_VAL);
            end
            return LEVEL_W'(v);
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ATTACK_STEPS:   attack_span  = data[STEP_COUNT_BITS-1:0];
                REG_ATTACK_INC:     attack_inc   = data[LEVEL_W-1:0];
                REG_DECAY_STEPS:    decay_span   = data[STEP_COUNT_BITS-1:0];
                REG_DECAY_FACTOR:   decay_mul    = data[FACTOR_W-1:0];
                REG_RELEASE_STEPS:  release_span = data[STEP_COUNT_BITS-1:0];
                REG_RELEASE_FACTOR: release_mul  = data[FACTOR_W-1:0];
                REG_SUSTAIN_LEVEL:  sustain      = data[LEVEL_W-1:0];
                default: ;
            endcase
        endfunction

        // Exponential approach to sustain, slope from the 0.0001 overshoot ratio
        function void begin_decay();
            longint s, f, a;
            s = longint'(sat_level(longint'(sustain)));
            f = longint'(decay_mul);
            a = s - round_q(RATIO_DEC_VAL * (ONE_VAL - s));
            slope_add  = DELTA_W'(round_q(a * (ONE_VAL - f)));
            slope_mul  = LEVEL_W'(f);
            target     = LEVEL_W'(s);
            steps_left = decay_span;
            linear     = 1'b0;
            phase      = PH_DECAY;
        endfunction

        // Exponential fall toward zero from the current level, ratio 0.1
        function void begin_release();
            longint f, a;
            f = longint'(release_mul);
            a = -round_q(RATIO_REL_VAL * longint'(level));
            slope_add  = DELTA_W'(round_q(a * (ONE_VAL - f)));
            slope_mul  = LEVEL_W'(f);
            target     = '0;
            steps_left = release_span;
            linear     = 1'b0;
            phase      = PH_RELEASE;
        endfunction

        function void close_segment();
            level = target;
            if (phase == PH_ATTACK) begin
                begin_decay();
            end else if (phase == PH_DECAY) begin
                phase = PH_SUSTAIN;
            end else begin
                phase = PH_DONE;
            end
        endfunction

        // Advance the envelope for one accepted request
        function void note_request(adsr_in_t req);
            longint    smp, used, prod;
            int        guard;
            adsr_out_t want;
            case (req.opcode)
                OP_NOTE_ON: begin
                    level      = '0;
                    phase      = PH_ATTACK;
                    steps_left = attack_span;
                    slope_add  = DELTA_W'(longint'(attack_inc));
                    slope_mul  = LEVEL_W'(ONE_VAL);
                    target     = LEVEL_W'(ONE_VAL);
                    linear     = 1'b1;
                end
                OP_NOTE_OFF: begin_release();
                OP_SAMPLE: begin
                    smp  = longint'($signed(req.sample_in));
                    used = longint'(level);
                    for (guard = 0; guard < 4; guard++) begin
                        if (!(phase inside {PH_ATTACK, PH_DECAY, PH_RELEASE})) begin
                            used = longint'(level);
                            break;
                        end
                        // empty segment: snap now, next phase takes this sample
                        if (steps_left == 0) begin
                            close_segment();
                            continue;
                        end
                        if (linear) begin
                            level = sat_level(longint'(level) + longint'(slope_add));
                        end else begin
                            level = sat_level(round_q(longint'(level) * longint'(slope_mul))
                                              + longint'(slope_add));
                        end
                        used = longint'(level);
                        steps_left = steps_left - 1'b1;
                        if (steps_left == 0) begin
                            close_segment();
                        end
                        break;
                    end
                    prod = round_q(smp * used);
                    if (prod > SAMPLE_MAX_VAL) begin
                        prod = SAMPLE_MAX_VAL;
                    end
                    if (prod < SAMPLE_MIN_VAL) begin
                        prod = SAMPLE_MIN_VAL;
                    end
                    want.sample_out     = SAMPLE_BITS'(prod);
                    want.envelope_level = LEVEL_W'(used);
                    want.finished       = (phase == PH_DONE);
                    pending_outputs.push_back(want);
                end
                default: ;
            endcase
        endfunction

        function void check_output(adsr_out_t got);
            adsr_out_t want;
            if (pending_outputs.size() == 0) begin
                $error("unexpected result: sample_out %0d envelope_level %0d finished %0b",
                       got.sample_out, got.envelope_level, got.finished);
                mismatches++;
                return;
            end
            want = pending_outputs.pop_front();
            if (got.sample_out !== want.sample_out) begin
                $error("sample_out expected %0d actual %0d", want.sample_out, got.sample_out);
                mismatches++;
            end
            if (got.envelope_level !== want.envelope_level) begin
                $error("envelope_level expected %0d actual %0d",
                       want.envelope_level, got.envelope_level);
                mismatches++;
            end
            if (got.finished !== want.finished) begin
                $error("finished expected %0b actual %0b", want.finished, got.finished);
                mismatches++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    adsr_in_t              s_payload;
    logic                  m_valid;
    logic                  m_ready;
    adsr_out_t             m_payload;

    envelope_tracker       tracker = new();
    int unsigned           send_idle_pct;
    int unsigned           recv_idle_pct;
    logic [CFG_DATA_W-1:0] settings [NUM_REGS];

    adsr_envelope_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: check accepted results, stall at random
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                tracker.check_output(m_payload);
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Drive one request, with random idle cycles ahead of it
    task automatic send_request(opcode_t op, logic signed [SAMPLE_BITS-1:0] smp);
        adsr_in_t req;
        req.opcode    = op;
        req.sample_in = smp;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= req;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        tracker.note_request(req);
    endtask

    // Hold off the sender until every owed result is back and the block is quiet
    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.pending_outputs.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_settings();
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_reg_t'(i);
            cfg_data  <= settings[i];
            @(posedge aclk);
            while (!cfg_ready) begin
                @(posedge aclk);
            end
            tracker.write_reg(cfg_reg_t'(i), settings[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return SAMPLE_BITS'(SAMPLE_MAX_VAL);
            1:       return SAMPLE_BITS'(SAMPLE_MIN_VAL);
            2:       return '0;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Mostly short segments so every phase is visited; now and then a long one
    function automatic logic [CFG_DATA_W-1:0] pick_steps();
        if ($urandom_range(0, 9) == 0) begin
            return CFG_DATA_W'($urandom_range(1, 1048575));
        end
        return CFG_DATA_W'($urandom_range(1, 24));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_factor();
        if ($urandom_range(0, 3) == 0) begin
            return CFG_DATA_W'($urandom_range(0, 8388607));
        end
        return CFG_DATA_W'($urandom_range(6000000, 8388607));
    endfunction

    // Mostly full note sequences with random content, the rest loose requests;
    // sequences are cut short so the phase sends exactly count requests
    task automatic run_phase(int unsigned count);
        int unsigned sent;
        int unsigned n;
        opcode_t     op;
        sent = 0;
        while (sent < count) begin
            if (($urandom_range(0, 9) < 8) && (count - sent >= 2)) begin
                send_request(OP_NOTE_ON, SAMPLE_BITS'($urandom));
                n = $urandom_range(0, 70);
                if (n > count - sent - 2) begin
                    n = count - sent - 2;
                end
                repeat (n) send_request(OP_SAMPLE, pick_sample());
                send_request(OP_NOTE_OFF, SAMPLE_BITS'($urandom));
                sent += n + 2;
                n = $urandom_range(0, 40);
                if (n > count - sent) begin
                    n = count - sent;
                end
                repeat (n) send_request(OP_SAMPLE, pick_sample());
                sent += n;
            end else begin
                op = opcode_t'($urandom_range(0, 3));
                send_request(op, pick_sample());
                sent++;
            end
        end
    endtask

    // Stimulus sequence
    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_payload <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_ATTACK_STEPS;
        cfg_data  <= '0;
        send_idle_pct = 28;
        recv_idle_pct = 46;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // default registers: done phase, note off from zero, reserved opcode
        send_request(OP_SAMPLE, SAMPLE_BITS'(SAMPLE_MAX_VAL));
        send_request(OP_NOTE_OFF, '0);
        send_request(OP_SAMPLE, SAMPLE_BITS'(SAMPLE_MIN_VAL));
        send_request(OP_NOTE_ON, '0);
        send_request(OP_SAMPLE, SAMPLE_BITS'(SAMPLE_MAX_VAL));
        send_request(OP_SAMPLE, SAMPLE_BITS'(SAMPLE_MIN_VAL));
        send_request(OP_SAMPLE, '0);
        send_request(OP_RESERVED, SAMPLE_BITS'(SAMPLE_MAX_VAL));
        send_request(OP_SAMPLE, -24'sd1);
        send_request(OP_NOTE_OFF, SAMPLE_BITS'(SAMPLE_MIN_VAL));
        send_request(OP_SAMPLE, 24'sd1);
        drain();

        // short segments at the extremes: full attack step, zero decay factor
        settings[REG_ATTACK_STEPS]   = CFG_DATA_W'(2);
        settings[REG_ATTACK_INC]     = CFG_DATA_W'(ONE_VAL);
        settings[REG_DECAY_STEPS]    = CFG_DATA_W'(3);
        settings[REG_DECAY_FACTOR]   = '0;
        settings[REG_RELEASE_STEPS]  = CFG_DATA_W'(2);
        settings[REG_RELEASE_FACTOR] = CFG_DATA_W'(ONE_VAL - 1);
        settings[REG_SUSTAIN_LEVEL]  = '0;
        apply_settings();
        send_request(OP_NOTE_ON, '0);
        send_request(OP_SAMPLE, SAMPLE_BITS'(SAMPLE_MAX_VAL));
        send_request(OP_SAMPLE, SAMPLE_BITS'(SAMPLE_MIN_VAL));
        send_request(OP_SAMPLE, SAMPLE_BITS'(SAMPLE_MAX_VAL));
        send_request(OP_SAMPLE, SAMPLE_BITS'(SAMPLE_MIN_VAL));
        send_request(OP_SAMPLE, SAMPLE_BITS'(SAMPLE_MAX_VAL));
        send_request(OP_SAMPLE, SAMPLE_BITS'(SAMPLE_MAX_VAL));
        send_request(OP_NOTE_OFF, '0);
        send_request(OP_SAMPLE, SAMPLE_BITS'(SAMPLE_MAX_VAL));
        send_request(OP_SAMPLE, SAMPLE_BITS'(SAMPLE_MIN_VAL));
        send_request(OP_SAMPLE, SAMPLE_BITS'(SAMPLE_MAX_VAL));

        // random phases, each with its own register settings
        for (int k = 0; k < PHASE_COUNT; k++) begin
            drain();
            if (k < 3) begin
                send_idle_pct = 28;
                recv_idle_pct = 46;
            end else if (k < 6) begin
                send_idle_pct = 46;
                recv_idle_pct = 28;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (k)
                0: begin
                    settings[REG_ATTACK_STEPS]   = CFG_DATA_W'(1);
                    settings[REG_ATTACK_INC]     = '0;
                    settings[REG_DECAY_STEPS]    = CFG_DATA_W'(1);
                    settings[REG_DECAY_FACTOR]   = '0;
                    settings[REG_RELEASE_STEPS]  = CFG_DATA_W'(1);
                    settings[REG_RELEASE_FACTOR] = '0;
                    settings[REG_SUSTAIN_LEVEL]  = '0;
                end
                1: begin
                    settings[REG_ATTACK_STEPS]   = CFG_DATA_W'(1048575);
                    settings[REG_ATTACK_INC]     = CFG_DATA_W'(ONE_VAL);
                    settings[REG_DECAY_STEPS]    = CFG_DATA_W'(1048575);
                    settings[REG_DECAY_FACTOR]   = CFG_DATA_W'(ONE_VAL - 1);
                    settings[REG_RELEASE_STEPS]  = CFG_DATA_W'(1048575);
                    settings[REG_RELEASE_FACTOR] = CFG_DATA_W'(ONE_VAL - 1);
                    settings[REG_SUSTAIN_LEVEL]  = CFG_DATA_W'(ONE_VAL);
                end
                2: begin
                    settings[REG_ATTACK_STEPS]   = CFG_DATA_W'(RST_ATTACK_STEPS);
                    settings[REG_ATTACK_INC]     = CFG_DATA_W'(RST_ATTACK_INC);
                    settings[REG_DECAY_STEPS]    = CFG_DATA_W'(40);
                    settings[REG_DECAY_FACTOR]   = CFG_DATA_W'(RST_DECAY_FACTOR);
                    settings[REG_RELEASE_STEPS]  = CFG_DATA_W'(30);
                    settings[REG_RELEASE_FACTOR] = CFG_DATA_W'(RST_REL_FACTOR);
                    settings[REG_SUSTAIN_LEVEL]  = CFG_DATA_W'(ONE_VAL / 2);
                end
                default: begin
                    settings[REG_ATTACK_STEPS]   = pick_steps();
                    settings[REG_ATTACK_INC]     = CFG_DATA_W'($urandom_range(0, ONE_VAL));
                    settings[REG_DECAY_STEPS]    = pick_steps();
                    settings[REG_DECAY_FACTOR]   = pick_factor();
                    settings[REG_RELEASE_STEPS]  = pick_steps();
                    settings[REG_RELEASE_FACTOR] = pick_factor();
                    settings[REG_SUSTAIN_LEVEL]  = CFG_DATA_W'($urandom_range(0, ONE_VAL));
                end
            endcase
            apply_settings();
            run_phase(REQS_PER_PHASE);
        end

        drain();
        if (tracker.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(5_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/adsr_pkg.sv
rtl/core/adsr_datapath.sv
rtl/core/adsr_ctrl.sv
rtl/core/adsr_envelope_generator.sv
tb/tb_adsr_envelope_generator.sv
